@@ rtl/core/abvf_pkg.sv @@
// ----------------------------------------------------------------------------
// abvf_pkg: shared types and constants of the band-pass velocity filter
// Configuration record, controller command word, multiply step codes and
// the 32-bit saturation helper.
// ----------------------------------------------------------------------------
package abvf_pkg;

  localparam int unsigned AXES = 3;      // width of the item, fixed by the ports
  localparam int unsigned DATA_W = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_HIGHPASS_COEFF = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOWPASS_COEFF = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_FACTOR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEADZONE_THRESHOLD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_SCALE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_LIMIT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 3'd6;

  // reset values
  localparam logic [16:0] RST_HIGHPASS_COEFF = 17'd64225;
  localparam logic [16:0] RST_LOWPASS_COEFF = 17'd6554;
  localparam logic [16:0] RST_DECAY_FACTOR = 17'd64881;
  localparam logic [30:0] RST_DEADZONE_THRESHOLD = 31'd655;
  localparam logic [23:0] RST_OUTPUT_SCALE = 24'd65536;
  localparam logic [30:0] RST_VELOCITY_LIMIT = 31'd65536;
  localparam logic [15:0] RST_TIME_STEP = 16'd328;

  // multiply steps, issued in this order for every axis
  localparam logic [2:0] OP_HP = 3'd0;    // high-pass: alpha * d
  localparam logic [2:0] OP_LPN = 3'd1;   // low-pass: beta * new value
  localparam logic [2:0] OP_LPO = 3'd2;   // low-pass: (1 - beta) * old value
  localparam logic [2:0] OP_VEL = 3'd3;   // integrate: lowpass * time step
  localparam logic [2:0] OP_DEC = 3'd4;   // decay, dead zone and clamp
  localparam logic [2:0] OP_SCL = 3'd5;   // step = velocity * scale

  localparam logic [17:0] ONE_Q16 = 18'd65536;

  typedef struct packed {
    logic [16:0] highpass_coeff;
    logic [16:0] lowpass_coeff;
    logic [16:0] decay_factor;
    logic [30:0] deadzone_threshold;
    logic [23:0] output_scale;
    logic [30:0] velocity_limit;
    logic [15:0] time_step;
  } cfg_t;

  typedef struct packed {
    logic       load;      // capture the input word
    logic       diff;      // form the high-pass difference of the current axis
    logic       mul;       // register one product
    logic       wb;        // write the registered product back
    logic       publish;   // move the finished steps to the output register
    logic [2:0] op;
  } cmd_t;

  function automatic logic signed [31:0] sat32(input logic signed [41:0] x);
    logic signed [41:0] hi;
    logic signed [41:0] lo;
    hi = 42'sd2147483647;
    lo = -42'sd2147483648;
    if (x > hi) begin
      sat32 = 32'sh7fffffff;
    end else if (x < lo) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = x[31:0];
    end
  endfunction

endpackage

@@ rtl/core/accel_bandpass_velocity_filter_unit.sv @@
// ----------------------------------------------------------------------------
// accel_bandpass_velocity_filter_unit: three-axis band-pass velocity filter
// Top level: configuration registers, sequencer and datapath.
// ----------------------------------------------------------------------------
// One input word carries an acceleration sample per axis (signed Q16.16).
// Each axis runs a first-order high-pass, a first-order low-pass, a leaky
// integration into velocity with dead zone and symmetric clamp, and a final
// gain, all on its own state; the word produced holds the scaled velocity
// per axis, saturated to 32 bits. Products truncate toward zero. Every
// accepted word yields exactly one output word. All multiplies go
// through one shared 32x25 multiplier whose product is registered before
// write-back; an axis takes one difference step and then six
// multiply/write-back pairs, and the word is published to the output
// register after its last axis, once any stalled result has left it. A new
// word is taken only after the previous one is published. The output
// word sits in its own register, so the next input word is taken while a
// result still waits; in_stall is high while a word is in flight. Axes at
// or beyond AXIS_COUNT leave their step field at zero. Configuration writes
// are always taken (cfg_ready is tied high) and must only be issued while
// the block is idle; writes to an unknown index are dropped. Filter state
// clears on reset; no clearing pass is needed.
// ----------------------------------------------------------------------------
module accel_bandpass_velocity_filter_unit #(
  parameter int unsigned AXIS_COUNT = 3
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input words
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [31:0]                    in_accel_x,
  input  logic signed [31:0]                    in_accel_y,
  input  logic signed [31:0]                    in_accel_z,
  // output words
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [31:0]                    out_step_x,
  output logic signed [31:0]                    out_step_y,
  output logic signed [31:0]                    out_step_z,
  // configuration writes
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [abvf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [abvf_pkg::CFG_DATA_W-1:0]       cfg_data
);

  // axis counter width; one bit minimum for a single axis
  localparam int unsigned AXW = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;

  abvf_pkg::cfg_t cfg_r;
  abvf_pkg::cmd_t cmd;
  logic [AXW-1:0] axis;

  assign cfg_ready = 1'b1;

  // configuration registers; an unknown index falls through untouched
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.highpass_coeff <= abvf_pkg::RST_HIGHPASS_COEFF;
      cfg_r.lowpass_coeff <= abvf_pkg::RST_LOWPASS_COEFF;
      cfg_r.decay_factor <= abvf_pkg::RST_DECAY_FACTOR;
      cfg_r.deadzone_threshold <= abvf_pkg::RST_DEADZONE_THRESHOLD;
      cfg_r.output_scale <= abvf_pkg::RST_OUTPUT_SCALE;
      cfg_r.velocity_limit <= abvf_pkg::RST_VELOCITY_LIMIT;
      cfg_r.time_step <= abvf_pkg::RST_TIME_STEP;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        abvf_pkg::REG_HIGHPASS_COEFF: begin
          cfg_r.highpass_coeff <= cfg_data[16:0];
        end
        abvf_pkg::REG_LOWPASS_COEFF: begin
          cfg_r.lowpass_coeff <= cfg_data[16:0];
        end
        abvf_pkg::REG_DECAY_FACTOR: begin
          cfg_r.decay_factor <= cfg_data[16:0];
        end
        abvf_pkg::REG_DEADZONE_THRESHOLD: begin
          cfg_r.deadzone_threshold <= cfg_data[30:0];
        end
        abvf_pkg::REG_OUTPUT_SCALE: begin
          cfg_r.output_scale <= cfg_data[23:0];
        end
        abvf_pkg::REG_VELOCITY_LIMIT: begin
          cfg_r.velocity_limit <= cfg_data[30:0];
        end
        abvf_pkg::REG_TIME_STEP: begin
          cfg_r.time_step <= cfg_data[15:0];
        end
        default: begin
        end
      endcase
    end
  end

  // sequencer: one axis at a time, one multiply step at a time
  abvf_ctrl #(
    .AXIS_COUNT (AXIS_COUNT),
    .AXW        (AXW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .axis      (axis)
  );

  // datapath: filter state, shared multiplier, output register
  abvf_dp #(
    .AXIS_COUNT (AXIS_COUNT),
    .AXW        (AXW)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .axis       (axis),
    .cfg        (cfg_r),
    .in_accel_x (in_accel_x),
    .in_accel_y (in_accel_y),
    .in_accel_z (in_accel_z),
    .out_step_x (out_step_x),
    .out_step_y (out_step_y),
    .out_step_z (out_step_z)
  );

endmodule

@@ rtl/core/abvf_ctrl.sv @@
// ----------------------------------------------------------------------------
// abvf_ctrl: sequencer of the band-pass velocity filter
// Walks each axis through the difference step and six multiply steps, then
// hands the finished word to the output register.
// ----------------------------------------------------------------------------
module abvf_ctrl #(
  parameter int unsigned AXIS_COUNT = 3,
  parameter int unsigned AXW = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output abvf_pkg::cmd_t    cmd,
  output logic [AXW-1:0]    axis
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIFF = 3'd1;
  localparam logic [2:0] ST_MUL = 3'd2;
  localparam logic [2:0] ST_WB = 3'd3;
  localparam logic [2:0] ST_FIN = 3'd4;

  localparam logic [AXW-1:0] LAST_AXIS = AXW'(AXIS_COUNT - 1);

  logic [2:0]     state_r, state_nxt;
  logic [2:0]     op_r, op_nxt;
  logic [AXW-1:0] axis_r, axis_nxt;
  logic           out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    op_nxt = op_r;
    axis_nxt = axis_r;
    out_valid_nxt = out_valid_r;
    cmd = '0;
    cmd.op = op_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          axis_nxt = '0;
          state_nxt = ST_DIFF;
        end
      end
      ST_DIFF: begin
        cmd.diff = 1'b1;
        op_nxt = abvf_pkg::OP_HP;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
        state_nxt = ST_WB;
      end
      ST_WB: begin
        cmd.wb = 1'b1;
        if (op_r == abvf_pkg::OP_SCL) begin
          if (axis_r == LAST_AXIS) begin
            state_nxt = ST_FIN;
          end else begin
            axis_nxt = axis_r + 1'b1;
            state_nxt = ST_DIFF;
          end
        end else begin
          op_nxt = op_r + 3'd1;
          state_nxt = ST_MUL;
        end
      end
      ST_FIN: begin
        // hold until the previous word has left the output register
        if (!out_valid_r || !out_stall) begin
          cmd.publish = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      op_r <= abvf_pkg::OP_HP;
      axis_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      op_r <= op_nxt;
      axis_r <= axis_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign axis = axis_r;

`ifndef SYNTHESIS
  a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (axis_r <= LAST_AXIS))
    else $error("axis counter beyond last axis");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_DIFF && axis_r == '0))
    else $error("accepted word did not start at the first axis");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.publish |-> !(out_valid_r && out_stall))
    else $error("publish over a stalled output word");

  a_op_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL || state_r == ST_WB) |-> (op_r <= abvf_pkg::OP_SCL))
    else $error("multiply step code out of range");
`endif

endmodule

@@ rtl/core/abvf_dp.sv @@
// ----------------------------------------------------------------------------
// abvf_dp: datapath of the band-pass velocity filter
// Per-axis filter state, one shared 32x25 signed multiplier with a product
// register, truncating writeback, and the output register.
// ----------------------------------------------------------------------------
module abvf_dp #(
  parameter int unsigned AXIS_COUNT = 3,
  parameter int unsigned AXW = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  abvf_pkg::cmd_t      cmd,
  input  logic [AXW-1:0]      axis,
  input  abvf_pkg::cfg_t      cfg,
  input  logic signed [31:0]  in_accel_x,
  input  logic signed [31:0]  in_accel_y,
  input  logic signed [31:0]  in_accel_z,
  output logic signed [31:0]  out_step_x,
  output logic signed [31:0]  out_step_y,
  output logic signed [31:0]  out_step_z
);

  logic signed [31:0] in_arr [abvf_pkg::AXES];
  logic signed [31:0] out_arr [abvf_pkg::AXES];

  logic signed [31:0] samp_r [AXIS_COUNT];
  logic signed [31:0] hp_r [AXIS_COUNT];
  logic signed [31:0] last_r [AXIS_COUNT];
  logic signed [31:0] lp_r [AXIS_COUNT];
  logic signed [31:0] vel_r [AXIS_COUNT];
  logic signed [31:0] step_r [AXIS_COUNT];

  logic signed [31:0] d_r;
  logic signed [31:0] v_r;
  logic signed [40:0] t1_r;
  logic signed [56:0] prod_r;

  logic signed [31:0] a_op;
  logic signed [24:0] b_op;
  logic signed [17:0] lp_old_w;
  logic signed [40:0] trunc_w;
  logic signed [31:0] dec_sat;
  logic signed [32:0] dec_ext;
  logic signed [32:0] dec_mag;
  logic signed [32:0] lim_ext;
  logic signed [32:0] vel_new;

  assign in_arr[0] = in_accel_x;
  assign in_arr[1] = in_accel_y;
  assign in_arr[2] = in_accel_z;

  // weight of the old low-pass value, negative when beta exceeds one
  assign lp_old_w = $signed(abvf_pkg::ONE_Q16) - $signed({1'b0, cfg.lowpass_coeff});

  always_comb begin
    case (cmd.op)
      abvf_pkg::OP_HP: begin
        a_op = d_r;
        b_op = $signed({8'd0, cfg.highpass_coeff});
      end
      abvf_pkg::OP_LPN: begin
        a_op = hp_r[axis];
        b_op = $signed({8'd0, cfg.lowpass_coeff});
      end
      abvf_pkg::OP_LPO: begin
        a_op = lp_r[axis];
        b_op = {{7{lp_old_w[17]}}, lp_old_w};
      end
      abvf_pkg::OP_VEL: begin
        a_op = lp_r[axis];
        b_op = $signed({9'd0, cfg.time_step});
      end
      abvf_pkg::OP_DEC: begin
        a_op = v_r;
        b_op = $signed({8'd0, cfg.decay_factor});
      end
      abvf_pkg::OP_SCL: begin
        a_op = vel_r[axis];
        b_op = $signed({1'b0, cfg.output_scale});
      end
      default: begin
        a_op = '0;
        b_op = '0;
      end
    endcase
  end

  // drop 16 fraction bits, rounding toward zero
  assign trunc_w = prod_r[56:16] + 41'($unsigned(prod_r[56] && (prod_r[15:0] != 16'd0)));

  // decay result, dead zone, clamp
  always_comb begin
    dec_sat = abvf_pkg::sat32({trunc_w[40], trunc_w});
    dec_ext = {dec_sat[31], dec_sat};
    dec_mag = dec_ext[32] ? -dec_ext : dec_ext;
    lim_ext = $signed({2'b00, cfg.velocity_limit});
    vel_new = dec_ext;
    if (dec_mag < $signed({2'b00, cfg.deadzone_threshold})) begin
      vel_new = '0;
    end
    if (vel_new > lim_ext) begin
      vel_new = lim_ext;
    end
    if (vel_new < -lim_ext) begin
      vel_new = -lim_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= a_op * b_op;
    end
    if (cmd.diff) begin
      d_r <= abvf_pkg::sat32(42'(hp_r[axis]) + 42'(samp_r[axis]) - 42'(last_r[axis]));
    end
    if (cmd.wb && cmd.op == abvf_pkg::OP_LPN) begin
      t1_r <= trunc_w;
    end
    if (cmd.wb && cmd.op == abvf_pkg::OP_VEL) begin
      v_r <= abvf_pkg::sat32(42'(vel_r[axis]) + 42'(trunc_w));
    end
    if (cmd.wb && cmd.op == abvf_pkg::OP_SCL) begin
      step_r[axis] <= abvf_pkg::sat32(42'(trunc_w));
    end
    for (int k = 0; k < AXIS_COUNT; k++) begin
      if (cmd.load) begin
        samp_r[k] <= in_arr[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < AXIS_COUNT; k++) begin
        hp_r[k] <= '0;
        last_r[k] <= '0;
        lp_r[k] <= '0;
        vel_r[k] <= '0;
      end
    end else begin
      if (cmd.diff) begin
        last_r[axis] <= samp_r[axis];
      end
      if (cmd.wb) begin
        case (cmd.op)
          abvf_pkg::OP_HP: begin
            hp_r[axis] <= abvf_pkg::sat32(42'(trunc_w));
          end
          abvf_pkg::OP_LPO: begin
            lp_r[axis] <= abvf_pkg::sat32(42'(t1_r) + 42'(trunc_w));
          end
          abvf_pkg::OP_DEC: begin
            vel_r[axis] <= vel_new[31:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  for (genvar k = 0; k < abvf_pkg::AXES; k++) begin : g_out
    if (k < AXIS_COUNT) begin : g_used
      always_ff @(posedge clk) begin
        if (cmd.publish) begin
          out_arr[k] <= step_r[k];
        end
      end
    end else begin : g_unused
      assign out_arr[k] = '0;
    end
  end

  assign out_step_x = out_arr[0];
  assign out_step_y = out_arr[1];
  assign out_step_z = out_arr[2];

endmodule
